/* sv/fsl_pkg.sv */
`timescale 1ns / 1ps

package fsl_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int LINE_CHUNK  = 4096;
    localparam int IDX_W       = $clog2(PATTERN_MAX);
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int POS_W       = $clog2(LINE_CHUNK);
    localparam int CNT_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int OUT_DATA_W  = 80;

    localparam logic [7:0] NEWLINE = 8'h0A;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 3'd4;

    // report modes
    localparam logic [1:0] MODE_LINES         = 2'd0;
    localparam logic [1:0] MODE_COUNT         = 2'd1;
    localparam logic [1:0] MODE_FILES_WITH    = 2'd2;
    localparam logic [1:0] MODE_FILES_WITHOUT = 2'd3;

    // result kinds
    localparam logic [1:0] RK_LINE  = 2'd0;
    localparam logic [1:0] RK_COUNT = 2'd1;
    localparam logic [1:0] RK_FILE  = 2'd2;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_EOF  = 1'b1;

    typedef logic [PATTERN_MAX-1:0][7:0] t_bytes;

    typedef struct packed {
        t_bytes           pattern;
        logic [LEN_W-1:0] pattern_length;
        logic             invert;
        logic [1:0]       mode;
    } t_cfg;

    typedef struct packed {
        logic [1:0]       result_kind;
        logic [CNT_W-1:0] line_no;
        logic             match_found;
        logic [POS_W-1:0] match_start;
        logic [CNT_W-1:0] sel_total;
    } t_result;

endpackage

/* sv/fixed_string_line_filter_unit.sv */
`timescale 1ns / 1ps

// channel   direction  handshake                      payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser: kind, tdata: data_byte
// m_axis    out        m_axis_tvalid / m_axis_tready  tuser: result_kind, tdata: result
// cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// one word per cycle sustained while the result buffer has room; a word waits in
// the input register, and the scan stage handles it and writes the result buffer.
// a result is shown from the buffer's head register once its word has been scanned.
// reset is synchronous, active low; it clears line and file state, the configuration registers and the valid flags.
// a two-entry result buffer lets input continue while one result waits;
// input stalls only when both entries hold results.

module fixed_string_line_filter_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // data_byte
    input  logic                              s_axis_tuser,  // kind
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // line_no, match_found, match_start, sel_total, zero fill
    output logic [fsl_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic [1:0]                        m_axis_tuser,  // result_kind
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fsl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fsl_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import fsl_pkg::*;

    logic [CFG_DATA_W-1:0] r_pat_low;
    logic [CFG_DATA_W-1:0] r_pat_high;
    logic [LEN_W-1:0]      r_pat_len;
    logic                  r_invert;
    logic [1:0]            r_mode;

    logic       r_in_valid;
    logic       r_in_kind;
    logic [7:0] r_in_byte;

    t_cfg    cfg;
    logic    room;
    logic    fire;
    logic    push;
    t_result scan_result;
    t_result out_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= LEN_W'(1);
            r_invert   <= 1'b0;
            r_mode     <= MODE_LINES;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PATTERN_LOW:  r_pat_low  <= i_cfg_data;
                CFG_PATTERN_HIGH: r_pat_high <= i_cfg_data;
                CFG_PATTERN_LEN:  r_pat_len  <= i_cfg_data[LEN_W-1:0];
                CFG_INVERT:       r_invert   <= i_cfg_data[0];
                CFG_MODE:         r_mode     <= i_cfg_data[1:0];
                default:          ;
            endcase
        end
    end

    assign cfg.pattern        = {r_pat_high, r_pat_low};
    assign cfg.pattern_length = r_pat_len;
    assign cfg.invert         = r_invert;
    assign cfg.mode           = r_mode;

    assign fire          = r_in_valid && room;
    assign s_axis_tready = !r_in_valid || room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_kind <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    fsl_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (fire),
        .i_kind   (r_in_kind),
        .i_byte   (r_in_byte),
        .i_cfg    (cfg),
        .o_push   (push),
        .o_result (scan_result)
    );

    fsl_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (scan_result),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (out_result),
        .o_room  (room)
    );

    assign m_axis_tuser = out_result.result_kind;
    assign m_axis_tdata = {3'b000, out_result.sel_total, out_result.match_start,
                           out_result.match_found, out_result.line_no};

    a_skid_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !room |-> m_axis_tvalid)
        else $error("result skid entry held without a head entry");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == RK_LINE || m_axis_tuser == RK_COUNT ||
                           m_axis_tuser == RK_FILE))
        else $error("undefined result kind");

    a_line_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == RK_LINE) |->
            (out_result.line_no != '0) && (out_result.sel_total == '0))
        else $error("line result with bad line number or count");

    a_file_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != RK_LINE) |->
            (out_result.line_no == '0) && !out_result.match_found &&
            (out_result.match_start == '0))
        else $error("file result carries line fields");

endmodule

/* sv/fsl_match.sv */
`timescale 1ns / 1ps

module fsl_match (
    input  fsl_pkg::t_bytes                i_window,
    input  fsl_pkg::t_bytes                i_pattern,
    input  logic [fsl_pkg::LEN_W-1:0]      i_len,
    output logic                           o_equal
);
    import fsl_pkg::*;

    logic [LEN_W:0] idx;

    // pattern byte i lines up with window byte PATTERN_MAX - len + i
    always_comb begin
        o_equal = 1'b1;
        idx     = '0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            idx = (LEN_W + 1)'(PATTERN_MAX) - {1'b0, i_len} + (LEN_W + 1)'(i);
            if ((LEN_W + 1)'(i) < {1'b0, i_len}) begin
                if (i_window[idx[IDX_W-1:0]] != i_pattern[i]) begin
                    o_equal = 1'b0;
                end
            end
        end
    end

endmodule

/* sv/fsl_scan.sv */
`timescale 1ns / 1ps

module fsl_scan (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_kind,
    input  logic [7:0]       i_byte,
    input  fsl_pkg::t_cfg    i_cfg,
    output logic             o_push,
    output fsl_pkg::t_result o_result
);
    import fsl_pkg::*;

    t_bytes           r_recent, n_recent;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_has, n_has;
    logic [POS_W-1:0] r_first, n_first;
    logic [CNT_W-1:0] r_lines, n_lines;
    logic [CNT_W-1:0] r_selcnt, n_selcnt;
    logic             r_stopped, n_stopped;

    t_bytes           win;
    logic [LEN_W-1:0] len;
    logic [POS_W-1:0] pos_new;
    logic             equal;
    logic             hit;
    logic             byte_ok;
    logic             eof;
    logic             do_end;
    logic             has_e;
    logic [POS_W-1:0] first_e;
    logic             found;
    logic [POS_W-1:0] start;
    logic             sel;
    logic [CNT_W-1:0] lines_inc;
    logic [CNT_W-1:0] sel_inc;
    logic             line_push;
    logic             file_push;

    fsl_match u_match (
        .i_window  (win),
        .i_pattern (i_cfg.pattern),
        .i_len     (len),
        .o_equal   (equal)
    );

    always_comb begin
        len = (i_cfg.pattern_length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                           : i_cfg.pattern_length;
        for (int i = 0; i < PATTERN_MAX - 1; i++) begin
            win[i] = r_recent[i+1];
        end
        win[PATTERN_MAX-1] = i_byte;
        pos_new = r_pos + POS_W'(1);

        byte_ok = i_valid && (i_kind == KIND_BYTE) && !r_stopped;
        eof     = i_valid && (i_kind == KIND_EOF);

        hit = !r_has && (len != '0) && (pos_new >= POS_W'(len)) && equal;

        if (eof) begin
            has_e   = r_has;
            first_e = r_first;
            do_end  = !r_stopped && (r_pos != '0);
        end else begin
            has_e   = r_has || hit;
            first_e = hit ? (pos_new - POS_W'(len)) : r_first;
            do_end  = byte_ok && ((i_byte == NEWLINE) || (pos_new >= POS_W'(LINE_CHUNK - 1)));
        end

        // empty pattern matches every line at offset zero
        found = (len == '0) || has_e;
        start = ((len != '0) && has_e) ? first_e : '0;
        sel   = do_end && (found ^ i_cfg.invert);

        lines_inc = (r_lines != '1) ? r_lines + CNT_W'(1) : r_lines;
        sel_inc   = (r_selcnt != '1) ? r_selcnt + CNT_W'(1) : r_selcnt;
        n_lines   = do_end ? lines_inc : r_lines;
        n_selcnt  = sel ? sel_inc : r_selcnt;

        line_push = sel && (i_cfg.mode == MODE_LINES);
        case (i_cfg.mode)
            MODE_COUNT:         file_push = eof;
            MODE_FILES_WITH:    file_push = eof && (n_selcnt != '0);
            MODE_FILES_WITHOUT: file_push = eof && (n_selcnt == '0);
            default:            file_push = 1'b0;
        endcase
        o_push = line_push || file_push;

        o_result = '0;
        if (line_push) begin
            o_result.result_kind = RK_LINE;
            o_result.line_no     = n_lines;
            o_result.match_found = found;
            o_result.match_start = start;
        end else begin
            o_result.result_kind = (i_cfg.mode == MODE_COUNT) ? RK_COUNT : RK_FILE;
            o_result.sel_total   = n_selcnt;
        end

        n_recent  = r_recent;
        n_pos     = r_pos;
        n_has     = r_has;
        n_first   = r_first;
        n_stopped = r_stopped;
        if (eof) begin
            n_recent  = '0;
            n_pos     = '0;
            n_has     = 1'b0;
            n_first   = '0;
            n_lines   = '0;
            n_selcnt  = '0;
            n_stopped = 1'b0;
        end else if (byte_ok) begin
            if (do_end) begin
                n_recent = '0;
                n_pos    = '0;
                n_has    = 1'b0;
                n_first  = '0;
                if (sel && ((i_cfg.mode == MODE_FILES_WITH) ||
                            (i_cfg.mode == MODE_FILES_WITHOUT))) begin
                    n_stopped = 1'b1;
                end
            end else begin
                n_recent = win;
                n_pos    = pos_new;
                n_has    = has_e;
                n_first  = first_e;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent  <= '0;
            r_pos     <= '0;
            r_has     <= 1'b0;
            r_first   <= '0;
            r_lines   <= '0;
            r_selcnt  <= '0;
            r_stopped <= 1'b0;
        end else begin
            r_recent  <= n_recent;
            r_pos     <= n_pos;
            r_has     <= n_has;
            r_first   <= n_first;
            r_lines   <= n_lines;
            r_selcnt  <= n_selcnt;
            r_stopped <= n_stopped;
        end
    end

endmodule

/* sv/fsl_outq.sv */
`timescale 1ns / 1ps

module fsl_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fsl_pkg::t_result i_data,
    input  logic             i_ready,
    output logic             o_valid,
    output fsl_pkg::t_result o_data,
    output logic             o_room
);
    import fsl_pkg::*;

    logic    r_head_valid, n_head_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_head, n_head;
    t_result r_skid, n_skid;
    logic    pop;

    // push is only offered while the skid slot is free
    always_comb begin
        pop          = r_head_valid && i_ready;
        n_head_valid = r_head_valid;
        n_skid_valid = r_skid_valid;
        n_head       = r_head;
        n_skid       = r_skid;
        if (!r_head_valid || pop) begin
            if (r_skid_valid) begin
                n_head       = r_skid;
                n_head_valid = 1'b1;
                n_skid_valid = i_push;
                n_skid       = i_data;
            end else begin
                n_head       = i_data;
                n_head_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_head_valid <= n_head_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_head <= n_head;
        r_skid <= n_skid;
    end

    assign o_valid = r_head_valid;
    assign o_data  = r_head;
    assign o_room  = !r_skid_valid;

endmodule
